@@ hdl/irig_timestamp_to_tick_code_core_macros.svh @@
// Assertion helpers shared by the time code core.
`ifndef IRIG_TIMESTAMP_TO_TICK_CODE_CORE_MACROS_SVH
`define IRIG_TIMESTAMP_TO_TICK_CODE_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ITC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ITC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ hdl/itc_pkg.sv @@
`default_nettype none
package itc_pkg;

    // Datapath widths
    localparam int ACC_W   = 60;  // tick count, signed
    localparam int MUL_A_W = 34;  // running year, day, hour, minute or second count, signed
    localparam int MUL_K_W = 27;  // multiplier constant, unsigned

    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic        [MUL_K_W-1:0] mul_k_t;

    // Scale factors applied one per step
    localparam mul_k_t K_DAYS_PER_YEAR  = 27'd365;
    localparam mul_k_t K_HOURS_PER_DAY  = 27'd24;
    localparam mul_k_t K_MINS_PER_HOUR  = 27'd60;
    localparam mul_k_t K_SECS_PER_MIN   = 27'd60;
    localparam mul_k_t K_TICKS_PER_SEC  = 27'd100000000;

    // Years from 1970 to 2000
    localparam logic [7:0] EPOCH_YEAR_OFFSET = 8'd30;
    // Day at or beyond which day 1 marks a new year
    localparam logic [8:0] YEAR_END_DAY      = 9'd365;
    // Year past 2000 from which 2100 is behind us (not a leap year)
    localparam logic [6:0] YEAR_PAST_2100    = 7'd101;

endpackage
`default_nettype wire

@@ hdl/irig_timestamp_to_tick_code_core.sv @@
`default_nettype none
// Converts one IRIG time stamp per item into a signed count of 10 ns ticks since
// the 1970 epoch. A full stamp (s_tuser = 0) runs through a shared multiply-add
// unit in five steps: days, hours, minutes, seconds, then ticks. A test stamp
// (s_tuser = 1) needs only the final tick step. A new item is taken only after
// the final step has moved the last result into the output register. A missing
// year (zero) is taken from the previous full stamp, advanced on a day 1 after
// day 365 or later, or from cfg_wdata's register on the first full stamp after
// reset. The result sits in an output register, so a new item is taken while
// the last result still waits on m_tready.
`include "irig_timestamp_to_tick_code_core_macros.svh"
module irig_timestamp_to_tick_code_core (
    input  wire         aclk,
    input  wire         aresetn,
    // Host year register
    input  wire         cfg_we,
    input  wire  [6:0]  cfg_wdata,
    // Time stamp items
    input  wire         s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: year[6:0], day[15:7], hour[20:16], minute[26:21],
    // second[32:27], subsecond[59:33], test_seconds[91:60], zero fill[95:92]
    input  wire  [95:0] s_tdata,
    // s_tuser: opcode[0]
    input  wire  [0:0]  s_tuser,
    // Tick code items
    output logic        m_tvalid,
    input  wire         m_tready,
    // m_tdata from bit 0: timecode[59:0], year_used[66:60], zero fill[71:67]
    output logic [71:0] m_tdata
);
    import itc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DAYS  = 3'd1;
    localparam logic [2:0] ST_HOUR  = 3'd2;
    localparam logic [2:0] ST_MIN   = 3'd3;
    localparam logic [2:0] ST_SEC   = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    // Unpack the input item
    logic               in_opcode;
    logic        [6:0]  in_year;
    logic        [8:0]  in_day;
    logic        [4:0]  in_hour;
    logic        [5:0]  in_minute;
    logic        [5:0]  in_second;
    logic        [26:0] in_subsec;
    logic signed [31:0] in_test_sec;

    assign in_opcode   = s_tuser[0];
    assign in_year     = s_tdata[6:0];
    assign in_day      = s_tdata[15:7];
    assign in_hour     = s_tdata[20:16];
    assign in_minute   = s_tdata[26:21];
    assign in_second   = s_tdata[32:27];
    assign in_subsec   = s_tdata[59:33];
    assign in_test_sec = $signed(s_tdata[91:60]);

    logic [2:0]  state_reg, state_next;
    logic [6:0]  host_year_reg;
    logic        have_last_reg;
    logic [6:0]  last_year_reg;
    logic [8:0]  last_day_reg;
    logic [6:0]  year_reg;
    logic [8:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [26:0] subsec_reg;
    acc_t        acc_reg;
    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;

    logic        accept;
    logic        out_free;
    logic [6:0]  year_fill;
    logic [6:0]  year_res;
    logic [7:0]  leaps;
    logic signed [10:0] day_off;
    mul_k_t      mul_k;
    acc_t        addend;
    acc_t        mac_result;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Resolve a missing year from the last full stamp or the host year
    always_comb begin
        if (!have_last_reg) begin
            year_fill = host_year_reg;
        end else if (in_day == 9'd1 && last_day_reg >= YEAR_END_DAY) begin
            year_fill = last_year_reg + 7'd1;
        end else begin
            year_fill = last_year_reg;
        end
        year_res = (in_year != 7'd0) ? in_year : year_fill;
    end

    // Leap days between 1970 and the stamp's year, plus day of year less one
    always_comb begin
        leaps   = ({1'b0, year_reg} + 8'd31) >> 2;
        day_off = $signed({3'b000, leaps}) + $signed({2'b00, day_reg}) - 11'sd1
                  - ((year_reg >= YEAR_PAST_2100) ? 11'sd1 : 11'sd0);
    end

    // Select constant and addend for the current step
    always_comb begin
        case (state_reg)
            ST_DAYS: begin
                mul_k  = K_DAYS_PER_YEAR;
                addend = {{(ACC_W - 11){day_off[10]}}, day_off};
            end
            ST_HOUR: begin
                mul_k  = K_HOURS_PER_DAY;
                addend = {{(ACC_W - 5){1'b0}}, hour_reg};
            end
            ST_MIN: begin
                mul_k  = K_MINS_PER_HOUR;
                addend = {{(ACC_W - 6){1'b0}}, minute_reg};
            end
            ST_SEC: begin
                mul_k  = K_SECS_PER_MIN;
                addend = {{(ACC_W - 6){1'b0}}, second_reg};
            end
            default: begin
                mul_k  = K_TICKS_PER_SEC;
                addend = {{(ACC_W - 27){1'b0}}, subsec_reg};
            end
        endcase
    end

    itc_mac u_mac (
        .mul_a  (acc_reg[MUL_A_W-1:0]),
        .mul_k  (mul_k),
        .addend (addend),
        .result (mac_result)
    );

    // Step sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = in_opcode ? ST_FINAL : ST_DAYS;
                end
            end
            ST_DAYS:  state_next = ST_HOUR;
            ST_HOUR:  state_next = ST_MIN;
            ST_MIN:   state_next = ST_SEC;
            ST_SEC:   state_next = ST_FINAL;
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state, host year and last stamp history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            host_year_reg <= 7'd25;
            have_last_reg <= 1'b0;
            last_year_reg <= 7'd0;
            last_day_reg  <= 9'd0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                host_year_reg <= cfg_wdata;
            end
            if (accept && !in_opcode) begin
                have_last_reg <= 1'b1;
                last_year_reg <= year_res;
                last_day_reg  <= in_day;
            end
            if (state_reg == ST_FINAL && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Capture the item, advance the accumulator and load the result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            day_reg    <= in_day;
            hour_reg   <= in_hour;
            minute_reg <= in_minute;
            second_reg <= in_second;
            subsec_reg <= in_subsec;
            if (in_opcode) begin
                year_reg <= 7'd0;
                acc_reg  <= {{(ACC_W - 32){in_test_sec[31]}}, in_test_sec};
            end else begin
                year_reg <= year_res;
                acc_reg  <= {{(ACC_W - 8){1'b0}}, ({1'b0, year_res} + EPOCH_YEAR_OFFSET)};
            end
        end else if (state_reg != ST_IDLE && state_reg != ST_FINAL) begin
            acc_reg <= mac_result;
        end
        if (state_reg == ST_FINAL && out_free) begin
            m_tdata_reg <= {5'd0, year_reg, mac_result};
        end
    end

    `ITC_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready,
                "input accepted while a conversion is under way")
    `ITC_ASSERT(a_final_holds, (state_reg == ST_FINAL && !out_free) |=> (state_reg == ST_FINAL),
                "final step left while the output register was full")
    `ITC_ASSERT(a_result_from_final, $rose(m_tvalid) |-> ($past(state_reg) == ST_FINAL),
                "result raised without a final step")
    `ITC_ASSERT_ALWAYS(a_history_kept, (aresetn && have_last_reg) |=> (!aresetn || have_last_reg),
                "stamp history lost outside reset")

endmodule
`default_nettype wire

@@ hdl/itc_mac.sv @@
`default_nettype none
module itc_mac (
    input  wire itc_pkg::mul_a_t mul_a,
    input  wire itc_pkg::mul_k_t mul_k,
    input  wire itc_pkg::acc_t   addend,
    output itc_pkg::acc_t        result
);
    import itc_pkg::*;

    logic signed [MUL_A_W+MUL_K_W:0] product;
    logic signed [MUL_A_W+MUL_K_W:0] sum;

    // Multiply by an unsigned constant, then add
    always_comb begin
        product = mul_a * $signed({1'b0, mul_k});
        sum     = product + {{(MUL_A_W + MUL_K_W + 1 - ACC_W){addend[ACC_W-1]}}, addend};
        result  = sum[ACC_W-1:0];
    end

endmodule
`default_nettype wire

@@ dv/irig_timestamp_to_tick_code_core_tb.sv @@
`timescale 1ns / 100ps
module irig_timestamp_to_tick_code_core_tb;

    localparam bit     OP_FULL        = 1'b0;
    localparam bit     OP_TEST        = 1'b1;
    localparam longint TICKS_PER_SEC  = 100000000;
    localparam int     YEAR_END_DAY   = 365;
    localparam int     NUM_DIRECTED   = 22;
    localparam int     NUM_PHASES     = 4;
    localparam int     ITEMS_PER_PHASE = 263;
    localparam int     STEADY_FIRST   = 500;
    localparam int     STEADY_LAST    = 699;
    localparam int     HOLD_AT        = 150;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     STALL_LIMIT    = 3000;

    typedef struct {
        bit               opcode;
        bit        [6:0]  year;
        bit        [8:0]  day;
        bit        [4:0]  hour;
        bit        [5:0]  minute;
        bit        [5:0]  second;
        bit        [26:0] subsecond;
        bit signed [31:0] test_seconds;
    } stamp_t;

    typedef struct {
        bit [59:0] timecode;
        bit [6:0]  year_used;
    } tick_res_t;

    typedef struct {
        stamp_t    st;
        bit        typed;
        tick_res_t res;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    // Mirror of the block's year tracking and host year register
    bit          have_prev;
    bit   [6:0]  prev_year;
    bit   [8:0]  prev_day;
    bit   [6:0]  host_year_q;
    bit   [8:0]  walk_day;

    tick_res_t   expected_ticks[$];
    dir_row_t    dir_rows[NUM_DIRECTED];
    int          errors;
    int          results_seen;
    int          stall_cycles;
    bit          steady;
    bit          held_off;

    irig_timestamp_to_tick_code_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Convert one stamp to epoch ticks and advance the year tracking
    function automatic tick_res_t convert_stamp(stamp_t st);
        tick_res_t r;
        bit [6:0]  yr;
        longint    yr_full;
        longint    days;
        longint    secs;
        longint    code;
        if (st.opcode == OP_TEST) begin
            code = longint'(st.test_seconds) * TICKS_PER_SEC + longint'(st.subsecond);
            r.timecode  = code[59:0];
            r.year_used = 7'd0;
            return r;
        end
        yr = st.year;
        if (yr == 7'd0) begin
            if (!have_prev)
                yr = host_year_q;
            else if (st.day == 9'd1 && prev_day >= YEAR_END_DAY)
                yr = prev_year + 7'd1;
            else
                yr = prev_year;
        end
        yr_full = 2000 + longint'(yr);
        days = 365 * (yr_full - 1970) + (yr_full - 1969) / 4 - (yr_full - 1901) / 100
             + (yr_full - 1601) / 400 + longint'(st.day) - 1;
        secs = days * 86400 + longint'(st.hour) * 3600 + longint'(st.minute) * 60
             + longint'(st.second);
        code = secs * TICKS_PER_SEC + longint'(st.subsecond);
        have_prev = 1'b1;
        prev_year = yr;
        prev_day  = st.day;
        r.timecode  = code[59:0];
        r.year_used = yr;
        return r;
    endfunction

    function automatic dir_row_t mk_row(bit op, int yr, int dy, int hr, int mn, int sc,
                                        int ss, int ts, bit typed, longint code, int yu);
        dir_row_t row;
        row.st.opcode       = op;
        row.st.year         = 7'(yr);
        row.st.day          = 9'(dy);
        row.st.hour         = 5'(hr);
        row.st.minute       = 6'(mn);
        row.st.second       = 6'(sc);
        row.st.subsecond    = 27'(ss);
        row.st.test_seconds = ts;
        row.typed           = typed;
        row.res.timecode    = code[59:0];
        row.res.year_used   = 7'(yu);
        return row;
    endfunction

    // Mostly plausible stamps walking across year ends, with some out-of-range noise
    function automatic stamp_t rand_stamp();
        stamp_t st;
        int     pick;
        st.opcode = ($urandom_range(99) < 15) ? OP_TEST : OP_FULL;
        st.year   = ($urandom_range(99) < 60) ? 7'd0 : 7'($urandom_range(127));
        pick = $urandom_range(99);
        if (pick < 45) begin
            if (walk_day >= 9'(365 + $urandom_range(1)))
                walk_day = 9'd1;
            else
                walk_day = walk_day + 9'd1;
            st.day = walk_day;
        end else if (pick < 65) begin
            st.day = 9'd1;
        end else if (pick < 85) begin
            st.day = 9'($urandom_range(366, 364));
        end else if (pick < 95) begin
            st.day = 9'($urandom_range(366));
        end else begin
            st.day = 9'($urandom_range(511));
        end
        st.hour      = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
        st.minute    = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
        st.second    = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(60));
        st.subsecond = ($urandom_range(4) == 0) ? 27'($urandom)
                                                : 27'($urandom_range(99999999));
        st.test_seconds = $urandom;
        return st;
    endfunction

    // Offer one stamp, hold it until taken, then queue its expected tick code
    task automatic offer_stamp(stamp_t st, bit typed, tick_res_t typed_res);
        tick_res_t res;
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= st.opcode;
        s_tdata  <= {4'd0, st.test_seconds, st.subsecond, st.second, st.minute,
                     st.hour, st.day, st.year};
        do @(posedge aclk); while (!s_tready);
        res = convert_stamp(st);
        expected_ticks.push_back(typed ? typed_res : res);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge aclk);
    endtask

    task automatic set_host_year(bit [6:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        host_year_q = value;
    endtask

    // Stimulus
    initial begin
        tick_res_t no_res;
        int        n;
        bit [6:0]  phase_year[NUM_PHASES];
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 7'd0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        have_prev   = 1'b0;
        prev_year   = 7'd0;
        prev_day    = 9'd0;
        host_year_q = 7'd25;
        walk_day    = 9'd360;
        steady      = 1'b0;
        no_res      = '{default: '0};
        phase_year  = '{7'd0, 7'd99, 7'($urandom_range(127)), 7'd127};

        dir_rows = '{
            // test stamps ignore the IRIG fields; signed extremes of the seconds
            mk_row(OP_TEST, 99, 511, 31, 63, 63, 0, 0, 1, 0, 0),
            mk_row(OP_TEST, 0, 0, 0, 0, 0, 5, -1, 1, -64'sd99999995, 0),
            mk_row(OP_TEST, 127, 0, 0, 0, 0, 134217727, 2147483647, 1,
                   64'sd214748364834217727, 0),
            mk_row(OP_TEST, 0, 0, 0, 0, 0, 0, 32'sh8000_0000, 1,
                   -64'sd214748364800000000, 0),
            // first full stamp without a year takes the host year
            mk_row(OP_FULL, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(OP_FULL, 99, 365, 23, 59, 60, 99999999, 0, 0, 0, 0),
            // day 1 after day 365: advance the year
            mk_row(OP_FULL, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(OP_FULL, 0, 366, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(OP_FULL, 127, 366, 31, 63, 63, 134217727, -1, 0, 0, 0),
            // year wraps from 127 back to 0
            mk_row(OP_FULL, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(OP_FULL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(OP_FULL, 0, 511, 0, 0, 0, 0, 0, 0, 0, 0),
            // test stamp between full stamps leaves the year tracking alone
            mk_row(OP_TEST, 0, 1, 0, 0, 0, 0, 12345, 1, 64'sd1234500000000, 0),
            mk_row(OP_FULL, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(OP_FULL, 5, 364, 12, 30, 30, 0, 0, 0, 0, 0),
            // day 1 after day 364 keeps the year
            mk_row(OP_FULL, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(OP_FULL, 1, 60, 12, 0, 0, 0, 0, 0, 0, 0),
            // 2100 is not a leap year
            mk_row(OP_FULL, 100, 59, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(OP_FULL, 100, 60, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(OP_FULL, 101, 60, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(OP_FULL, 4, 366, 23, 59, 59, 0, 0, 0, 0, 0),
            mk_row(OP_FULL, 0, 365, 0, 0, 0, 0, 0, 0, 0, 0)
        };

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Host year beyond the usual range, seen by the first full stamp
        set_host_year(7'd127);
        foreach (dir_rows[i])
            offer_stamp(dir_rows[i].st, dir_rows[i].typed, dir_rows[i].res);

        n = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            set_host_year(phase_year[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                steady = (n >= STEADY_FIRST && n <= STEADY_LAST);
                offer_stamp(rand_stamp(), 1'b0, no_res);
                n++;
            end
            steady = 1'b0;
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side readiness, with one long hold-off to back the block up
    initial begin
        m_tready = 1'b0;
        held_off = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!held_off && results_seen >= HOLD_AT) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= steady || ($urandom_range(99) >= 23);
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge aclk) begin
        tick_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_ticks.size() == 0) begin
                $error("unexpected result item: timecode %0d", $signed(m_tdata[59:0]));
                errors++;
            end else begin
                want = expected_ticks.pop_front();
                if (m_tdata[59:0] !== want.timecode) begin
                    $error("timecode: expected %0d, got %0d",
                           $signed(want.timecode), $signed(m_tdata[59:0]));
                    errors++;
                end
                if (m_tdata[66:60] !== want.year_used) begin
                    $error("year_used: expected %0d, got %0d", want.year_used, m_tdata[66:60]);
                    errors++;
                end
            end
        end
    end

    // Drop the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles++;
        end
    end

endmodule
